>>> rtl/core/dpcd_pkg.sv
// Shared types and constants for the delta patch command decoder.
package dpcd_pkg;

   localparam logic [6:0]  GROUP_MASK   = 7'h7f;
   localparam logic [23:0] ZERO_LENGTH  = 24'h010000;
   localparam logic [5:0]  SHIFT_LIMIT  = 6'd28;
   localparam logic [5:0]  SHIFT_STEP   = 6'd7;
   localparam int          OFFSET_BYTES = 4;
   localparam int          LENGTH_BYTES = 3;

   // result kinds
   localparam logic [1:0] KIND_TARGET_SIZE = 2'd0;
   localparam logic [1:0] KIND_COPY        = 2'd1;
   localparam logic [1:0] KIND_LITERAL     = 2'd2;
   localparam logic [1:0] KIND_ERROR       = 2'd3;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_BASE_SIZE = 3'd1;
   localparam logic [2:0] ERR_RANGE     = 3'd2;
   localparam logic [2:0] ERR_ZERO_OP   = 3'd3;
   localparam logic [2:0] ERR_TRUNC     = 3'd4;

   typedef enum logic [4:0] {
      PH_SRC  = 5'b00001,
      PH_TGT  = 5'b00010,
      PH_OP   = 5'b00100,
      PH_COPY = 5'b01000,
      PH_LIT  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0] delta_byte;
      logic       end_of_delta;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] copy_offset;
      logic [23:0] copy_length;
      logic [7:0]  literal_value;
      logic [31:0] target_size;
      logic [2:0]  error_code;
      logic        last;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] varint_accum;
      logic [5:0]  varint_shift;
      logic [6:0]  pending_mask;
      logic [31:0] offset_accum;
      logic [23:0] length_accum;
      logic [6:0]  literals_left;
      logic        error_latched;
   } ctx_type;

   localparam ctx_type CTX_RESET = '{
      phase:         PH_SRC,
      varint_accum:  32'd0,
      varint_shift:  6'd0,
      pending_mask:  7'd0,
      offset_accum:  32'd0,
      length_accum:  24'd0,
      literals_left: 7'd0,
      error_latched: 1'b0
   };

endpackage

>>> rtl/core/dpcd_step.sv
// Per-byte decode: next context and the optional result for one delta byte.
module dpcd_step (
   input  dpcd_pkg::ctx_type ctx,
   input  dpcd_pkg::req_type req,
   input  logic [31:0]       base_size,
   output dpcd_pkg::ctx_type ctx_next,
   output dpcd_pkg::rsp_type rsp,
   output logic              have
);
   import dpcd_pkg::*;

   logic [7:0]  b;
   logic [31:0] acc;
   logic [31:0] off;
   logic [23:0] len;
   logic [23:0] len_eff;
   logic [32:0] range_end;
   logic [6:0]  low_bit;
   logic [2:0]  err;
   logic        copy_done;

   assign b = req.delta_byte;

   always_comb begin
      ctx_next  = ctx;
      rsp       = '0;
      have      = 1'b0;
      err       = ERR_NONE;
      copy_done = 1'b0;
      acc       = ctx.varint_accum;
      off       = ctx.offset_accum;
      len       = ctx.length_accum;
      low_bit   = ctx.pending_mask & (~ctx.pending_mask + 7'd1);
      len_eff   = '0;
      range_end = '0;

      if (ctx.error_latched) begin
         if (req.end_of_delta) begin
            ctx_next = CTX_RESET;
         end
      end else begin
         case (ctx.phase)
            PH_SRC, PH_TGT: begin
               if (ctx.varint_shift >= SHIFT_LIMIT && b[7:4] != 4'd0) begin
                  err = ERR_TRUNC;
               end else begin
                  acc = ctx.varint_accum
                        | ({25'd0, b[6:0] & GROUP_MASK} << ctx.varint_shift[4:0]);
                  ctx_next.varint_accum = acc;
                  ctx_next.varint_shift = ctx.varint_shift + SHIFT_STEP;
                  if (!b[7]) begin
                     if (ctx.phase == PH_SRC) begin
                        if (acc != base_size) begin
                           err = ERR_BASE_SIZE;
                        end else begin
                           ctx_next.phase        = PH_TGT;
                           ctx_next.varint_accum = '0;
                           ctx_next.varint_shift = '0;
                        end
                     end else begin
                        rsp.kind        = KIND_TARGET_SIZE;
                        rsp.target_size = acc;
                        have            = 1'b1;
                        ctx_next.phase  = PH_OP;
                     end
                  end
               end
            end
            PH_COPY: begin
               for (int i = 0; i < OFFSET_BYTES; i++) begin
                  if (low_bit[i]) begin
                     off[8*i +: 8] = off[8*i +: 8] | b;
                  end
               end
               for (int i = 0; i < LENGTH_BYTES; i++) begin
                  if (low_bit[OFFSET_BYTES + i]) begin
                     len[8*i +: 8] = len[8*i +: 8] | b;
                  end
               end
               ctx_next.pending_mask = ctx.pending_mask & (ctx.pending_mask - 7'd1);
               ctx_next.offset_accum = off;
               ctx_next.length_accum = len;
               copy_done = (ctx_next.pending_mask == 7'd0);
            end
            PH_LIT: begin
               rsp.kind               = KIND_LITERAL;
               rsp.literal_value      = b;
               have                   = 1'b1;
               ctx_next.literals_left = ctx.literals_left - 7'd1;
               if (ctx_next.literals_left == 7'd0) begin
                  ctx_next.phase = PH_OP;
               end
            end
            default: begin
               // opcode byte
               if (b[7]) begin
                  off                   = '0;
                  len                   = '0;
                  ctx_next.pending_mask = b[6:0];
                  ctx_next.offset_accum = '0;
                  ctx_next.length_accum = '0;
                  if (b[6:0] == 7'd0) begin
                     copy_done = 1'b1;
                  end else begin
                     ctx_next.phase = PH_COPY;
                  end
               end else if (b != 8'd0) begin
                  ctx_next.literals_left = b[6:0];
                  ctx_next.phase         = PH_LIT;
               end else begin
                  err = ERR_ZERO_OP;
               end
            end
         endcase

         if (copy_done) begin
            len_eff        = (len == 24'd0) ? ZERO_LENGTH : len;
            range_end      = {1'b0, off} + {9'd0, len_eff};
            ctx_next.phase = PH_OP;
            if (range_end > {1'b0, base_size}) begin
               err = ERR_RANGE;
            end else begin
               rsp.kind        = KIND_COPY;
               rsp.copy_offset = off;
               rsp.copy_length = len_eff;
               have            = 1'b1;
            end
         end

         // stream ended mid-instruction or mid-header
         if (err == ERR_NONE && req.end_of_delta && ctx_next.phase != PH_OP) begin
            err = ERR_TRUNC;
         end

         if (err != ERR_NONE) begin
            rsp            = '0;
            rsp.kind       = KIND_ERROR;
            rsp.error_code = err;
            have           = 1'b1;
            if (!req.end_of_delta) begin
               ctx_next.error_latched = 1'b1;
            end
         end

         if (req.end_of_delta) begin
            rsp.last = have;
            ctx_next = CTX_RESET;
         end
      end
   end

endmodule

>>> rtl/core/dpcd_ctx.sv
// Decoder context registers: phase, header varint and copy/literal progress.
module dpcd_ctx (
   input  logic              clock,
   input  logic              reset,
   input  logic              update,
   input  dpcd_pkg::ctx_type ctx_in,
   output dpcd_pkg::ctx_type ctx_ff
);
   import dpcd_pkg::*;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= CTX_RESET;
      end else if (update) begin
         ctx_ff <= ctx_in;
      end
   end

endmodule

>>> rtl/core/delta_patch_command_decoder.sv
// Delta patch command decoder top level: input register, decode, result register.
// A transaction accepted into the input register is decoded into the result register,
//   from which its result (if any) can be taken.
// Throughput: one delta byte per cycle unless a stalled result blocks; the context update
//   is a single pass through the byte decoder, so back-to-back bytes are decoded without bubbles.
// While a result waits, the input register takes one more byte, then req_stall holds.
// Reset (synchronous, active high): clears valids and base_size to zero, sets the context to CTX_RESET.
module delta_patch_command_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dpcd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dpcd_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);
   import dpcd_pkg::*;

   // config
   logic [31:0] base_size_ff;

   // input stage
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;

   // result stage
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;

   // decode
   ctx_type ctx_ff;
   ctx_type ctx_in;
   rsp_type step_rsp;
   logic    step_have;
   logic    can_advance;
   logic    process;
   logic    req_take;

   // The result slot frees up this cycle if empty or being drained.
   assign can_advance = !out_valid_ff || !rsp_stall;
   // Decode the held byte and commit its context update.
   assign process     = in_valid_ff && can_advance;
   assign req_stall   = in_valid_ff && !can_advance;
   assign req_take    = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (process ? 1'b0 : in_valid_ff);
   // Bytes with no result (headers, copy args, latched errors) leave the slot empty.
   assign out_valid_in = process ? step_have : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_size_ff <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            base_size_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_payload;
      end
      if (process) begin
         out_data_ff <= step_rsp;
      end
   end

   dpcd_step u_step (
      .ctx       (ctx_ff),
      .req       (in_data_ff),
      .base_size (base_size_ff),
      .ctx_next  (ctx_in),
      .rsp       (step_rsp),
      .have      (step_have)
   );

   dpcd_ctx u_ctx (
      .clock  (clock),
      .reset  (reset),
      .update (process),
      .ctx_in (ctx_in),
      .ctx_ff (ctx_ff)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

>>> verif/delta_check_pkg.sv
// Scoreboard for the delta decoder: predicts decoded commands and checks them.
`timescale 1ns / 1ps

package delta_check_pkg;

   import dpcd_pkg::*;

   class command_scoreboard;

      logic [31:0] base_size;
      phase_type   stage;
      logic [31:0] header_value;
      logic [5:0]  header_shift;
      logic [6:0]  arg_mask;
      logic [31:0] copy_off;
      logic [23:0] copy_len;
      logic [6:0]  literal_count;
      bit          err_latch;

      rsp_type pending_commands[$];
      int      errors;
      int      checked;
      int      kind_count[4];

      function new();
         base_size = '0;
         errors    = 0;
         checked   = 0;
         foreach (kind_count[i]) kind_count[i] = 0;
         clear_context();
      endfunction

      function void clear_context();
         stage         = PH_SRC;
         header_value  = '0;
         header_shift  = '0;
         arg_mask      = '0;
         copy_off      = '0;
         copy_len      = '0;
         literal_count = '0;
         err_latch     = 1'b0;
      endfunction

      function void set_base(logic [31:0] value);
         base_size = value;
      endfunction

      function int pending();
         return pending_commands.size();
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      // Decode one accepted byte; queue the command it yields, if any.
      function void note_byte(req_type item);
         logic [7:0]  b;
         logic [2:0]  err;
         logic [23:0] len;
         logic [32:0] span;
         bit          is_end;
         bit          have;
         bit          copy_done;
         int          k;
         rsp_type     res;
         b         = item.delta_byte;
         is_end    = item.end_of_delta;
         have      = 1'b0;
         copy_done = 1'b0;
         err       = ERR_NONE;
         res       = '0;
         if (err_latch) begin
            if (is_end) clear_context();
            return;
         end
         case (stage)
            PH_SRC, PH_TGT: begin
               if (header_shift >= SHIFT_LIMIT && b[7:4] != 4'd0) begin
                  err = ERR_TRUNC;
               end else begin
                  header_value = header_value | (32'(b[6:0]) << header_shift[4:0]);
                  header_shift = header_shift + SHIFT_STEP;
                  if (!b[7]) begin
                     if (stage == PH_SRC) begin
                        if (header_value != base_size) begin
                           err = ERR_BASE_SIZE;
                        end else begin
                           stage        = PH_TGT;
                           header_value = '0;
                           header_shift = '0;
                        end
                     end else begin
                        res.kind        = KIND_TARGET_SIZE;
                        res.target_size = header_value;
                        have            = 1'b1;
                        stage           = PH_OP;
                     end
                  end
               end
            end
            PH_COPY: begin
               k = 0;
               while (k < 7 && !arg_mask[k]) k++;
               if (k < OFFSET_BYTES) begin
                  copy_off = copy_off | (32'(b) << (8 * k));
               end else if (k < 7) begin
                  copy_len = copy_len | (24'(b) << (8 * (k - OFFSET_BYTES)));
               end
               if (k < 7) arg_mask[k] = 1'b0;
               if (arg_mask == 7'd0) copy_done = 1'b1;
            end
            PH_LIT: begin
               res.kind          = KIND_LITERAL;
               res.literal_value = b;
               have              = 1'b1;
               literal_count     = literal_count - 7'd1;
               if (literal_count == 7'd0) stage = PH_OP;
            end
            default: begin
               if (b[7]) begin
                  arg_mask = b[6:0];
                  copy_off = '0;
                  copy_len = '0;
                  if (arg_mask == 7'd0) copy_done = 1'b1;
                  else stage = PH_COPY;
               end else if (b != 8'd0) begin
                  literal_count = b[6:0];
                  stage         = PH_LIT;
               end else begin
                  err = ERR_ZERO_OP;
               end
            end
         endcase

         if (copy_done) begin
            len   = (copy_len == 24'd0) ? ZERO_LENGTH : copy_len;
            stage = PH_OP;
            span  = {1'b0, copy_off} + {9'd0, len};
            if (span > {1'b0, base_size}) begin
               err = ERR_RANGE;
            end else begin
               res.kind        = KIND_COPY;
               res.copy_offset = copy_off;
               res.copy_length = len;
               have            = 1'b1;
            end
         end

         if (err == ERR_NONE && is_end && stage != PH_OP) err = ERR_TRUNC;

         if (err != ERR_NONE) begin
            res            = '0;
            res.kind       = KIND_ERROR;
            res.error_code = err;
            have           = 1'b1;
            if (!is_end) err_latch = 1'b1;
         end

         if (is_end) begin
            if (have) res.last = 1'b1;
            clear_context();
         end
         if (have) pending_commands.push_back(res);
      endfunction

      task compare_field(string name, logic [31:0] got_v, logic [31:0] want_v);
         if (got_v !== want_v) begin
            report($sformatf("result %0d %s: got %0h, expected %0h",
                             checked, name, got_v, want_v));
         end
      endtask

      task check_command(rsp_type got);
         rsp_type want;
         if (pending_commands.size() == 0) begin
            report($sformatf("result with no command pending, kind %0d", got.kind));
            return;
         end
         want = pending_commands.pop_front();
         checked++;
         kind_count[want.kind]++;
         compare_field("kind", 32'(got.kind), 32'(want.kind));
         compare_field("copy_offset", got.copy_offset, want.copy_offset);
         compare_field("copy_length", 32'(got.copy_length), 32'(want.copy_length));
         compare_field("literal_value", 32'(got.literal_value), 32'(want.literal_value));
         compare_field("target_size", got.target_size, want.target_size);
         compare_field("error_code", 32'(got.error_code), 32'(want.error_code));
         compare_field("last", 32'(got.last), 32'(want.last));
      endtask

      task check_leftover();
         if (pending_commands.size() != 0) begin
            report($sformatf("%0d results never arrived", pending_commands.size()));
         end
      endtask

   endclass

endpackage

>>> verif/tb.sv
// Top-level testbench for the delta patch command decoder.
`timescale 1ns / 1ps

module tb;

   import dpcd_pkg::*;
   import delta_check_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_LIMIT = 50000;
   localparam int PHASE_BYTES = 112;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   command_scoreboard sb;

   // Bytes of the delta stream under construction; end flag set on send.
   req_type stream[$];
   int      bytes_sent;
   int      streams_sent;
   int      base_settings;
   int      cycle_count;
   bit      idle_on;

   delta_patch_command_decoder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------------------------------------------------------
   // Stream construction
   // ---------------------------------------------------------------
   function automatic void push_byte(logic [7:0] b);
      req_type r;
      r.delta_byte   = b;
      r.end_of_delta = 1'b0;
      stream.push_back(r);
   endfunction

   // Little-endian base-128; optional zero groups pad the encoding, but never
   // past the fifth group, which must stay below 16 to be legal.
   function automatic void push_varint(logic [31:0] value, int pad);
      int          groups;
      logic [31:0] t;
      groups = 1;
      t      = value >> 7;
      while (t != 0) begin
         groups++;
         t = t >> 7;
      end
      if (pad > 5 - groups) pad = 5 - groups;
      for (int i = 0; i < groups + pad; i++) begin
         push_byte({(i < groups + pad - 1), value[6:0]});
         value = value >> 7;
      end
   endfunction

   // Four continued groups, then a fifth carrying bits beyond 32.
   function automatic void push_overlong();
      for (int i = 0; i < 4; i++) push_byte({1'b1, 7'($urandom())});
      push_byte(8'($urandom_range(16, 255)));
   endfunction

   function automatic void push_copy(logic [31:0] base, bit fit);
      logic [31:0] off;
      logic [31:0] len;
      logic [31:0] lim;
      logic [23:0] enc;
      logic [6:0]  m;
      if (fit && base != 0) begin
         if (base >= 32'h10000 && $urandom_range(0, 5) == 0) begin
            len = 32'h10000;
         end else begin
            lim = ($urandom_range(0, 3) == 0) ? 32'hFF_FFFF : 32'd300;
            if (lim > base) lim = base;
            len = $urandom_range(1, lim);
         end
         // sometimes land exactly on the end of the base object
         off = ($urandom_range(0, 5) == 0) ? base - len : $urandom_range(0, base - len);
      end else begin
         off = $urandom();
         len = {8'd0, 24'($urandom())};
      end
      enc = len[23:0];
      if (len == 32'h10000 && $urandom_range(0, 1) == 0) enc = '0;
      // mask bits: needed for nonzero bytes, optional for zero bytes
      for (int i = 0; i < OFFSET_BYTES; i++) begin
         m[i] = (off[8*i +: 8] != 8'd0) || ($urandom_range(0, 3) == 0);
      end
      for (int i = 0; i < LENGTH_BYTES; i++) begin
         m[OFFSET_BYTES + i] = (enc[8*i +: 8] != 8'd0) || ($urandom_range(0, 3) == 0);
      end
      push_byte({1'b1, m});
      for (int i = 0; i < OFFSET_BYTES; i++) begin
         if (m[i]) push_byte(off[8*i +: 8]);
      end
      for (int i = 0; i < LENGTH_BYTES; i++) begin
         if (m[OFFSET_BYTES + i]) push_byte(enc[8*i +: 8]);
      end
   endfunction

   function automatic void push_literals();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 85) n = $urandom_range(1, 6);
      else if (r < 95) n = $urandom_range(7, 40);
      else n = $urandom_range(100, 127);
      push_byte(8'(n));
      repeat (n) push_byte(8'($urandom()));
   endfunction

   // Mostly well-formed deltas with random content; a share of noise,
   // bad headers, bad instructions and early ends.
   function automatic void build_stream(logic [31:0] base);
      int r;
      int p;
      int cut;
      int ops;
      stream.delete();
      r = $urandom_range(0, 99);
      if (r < 6) begin
         repeat ($urandom_range(1, 12)) push_byte(8'($urandom()));
      end else if (r < 16) begin
         // broken source header; the rest is ignored until the end byte
         if (r < 11) push_overlong();
         else push_varint(base ^ (32'd1 << $urandom_range(0, 31)), 0);
         repeat ($urandom_range(0, 2)) push_byte(8'($urandom()));
      end else begin
         push_varint(base, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
         if ($urandom_range(0, 19) == 0) begin
            push_overlong();
         end else begin
            push_varint(($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 300),
                        ($urandom_range(0, 4) == 0) ? 1 : 0);
         end
         ops = $urandom_range(0, 6);
         repeat (ops) begin
            p = $urandom_range(0, 99);
            if (p < 42) push_copy(base, 1'b1);
            else if (p < 50) push_copy(base, 1'b0);
            else if (p < 94) push_literals();
            else push_byte(8'h00);
         end
      end
      if ($urandom_range(0, 9) == 0 && stream.size() > 1) begin
         cut = $urandom_range(0, stream.size() - 2);
         while (stream.size() > cut + 1) void'(stream.pop_back());
      end
   endfunction

   // ---------------------------------------------------------------
   // Drivers: inputs move on the falling edge, handshakes are sampled
   // on the rising edge.
   // ---------------------------------------------------------------
   task automatic send_item(req_type item);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // transaction accepted at this edge
      sb.note_byte(item);
      bytes_sent++;
   endtask

   task automatic send_stream();
      stream[stream.size() - 1].end_of_delta = 1'b1;
      foreach (stream[i]) send_item(stream[i]);
      streams_sent++;
   endtask

   // Sender holds off until every expected result has come, then lets the
   // two-stage pipe settle for bytes that produce nothing.
   task automatic wait_idle();
      int n;
      n = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (8) @(posedge clock);
   endtask

   // Only called while idle.
   task automatic write_base(logic [31:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_base(value);
      base_settings++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Result side: random stall, with long and short runs.
   initial begin : stall_gen
      int run;
      rsp_stall = 1'b0;
      forever begin
         run = $urandom_range(1, 12);
         repeat (run) @(negedge clock);
         run = pick_gap();
         if (run > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (run - 1) @(negedge clock);
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every result transaction is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_command(rsp_payload);
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending());
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : main
      logic [31:0] base_choice;
      int          phase_start;
      sb            = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      bytes_sent    = 0;
      streams_sent  = 0;
      base_settings = 0;
      idle_on       = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed deltas, base size zero out of reset.
      // Empty instruction list: target size only, flagged last.
      stream = {};
      push_byte(8'h00); push_byte(8'h00);
      send_stream();
      // Opcode 0x80 alone: offset 0, length 64K, past a zero-size base.
      stream = {};
      push_byte(8'h00); push_byte(8'h05); push_byte(8'h80);
      send_stream();
      // Source size mismatch on the end byte.
      stream = {};
      push_byte(8'h01);
      send_stream();
      // Ends right after the source header.
      stream = {};
      push_byte(8'h00);
      send_stream();

      wait_idle();
      write_base(32'hFFFF_FFFF);
      // Header group at bit 28 with bits above 31 set.
      stream = {};
      push_byte(8'h80); push_byte(8'h80); push_byte(8'h80); push_byte(8'h80);
      push_byte(8'h10);
      send_stream();

      wait_idle();
      write_base(32'h0001_0000);
      // Copy of the whole base, two literals, zero opcode, then bytes
      // swallowed by the error latch including the end byte.
      stream = {};
      push_byte(8'h80); push_byte(8'h80); push_byte(8'h04); push_byte(8'h7f);
      push_byte(8'h80); push_byte(8'h02); push_byte(8'haa); push_byte(8'h55);
      push_byte(8'h00); push_byte(8'h34);
      send_stream();
      // Literal run cut short by the end byte.
      stream = {};
      push_byte(8'h80); push_byte(8'h80); push_byte(8'h04); push_byte(8'h00);
      push_byte(8'h03); push_byte(8'h01);
      send_stream();

      // Random deltas over a spread of base sizes; two settings run with
      // no idling on either side.
      for (int p = 0; p < 8; p++) begin
         case (p)
            0, 7:    base_choice = 32'hFFFF_FFFF;
            1:       base_choice = 32'd0;
            3:       base_choice = $urandom_range(1, 300);
            4:       base_choice = 32'h0001_0000;
            5:       base_choice = $urandom_range(32'h10000, 32'h100_0000);
            default: base_choice = $urandom();
         endcase
         wait_idle();
         write_base(base_choice);
         idle_on     = (p != 2 && p != 6);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            build_stream(base_choice);
            send_stream();
            if ($urandom_range(0, 7) == 0) wait_idle();
         end
      end

      wait_idle();
      sb.check_leftover();
      $display("run covered %0d delta bytes in %0d streams over %0d base size settings",
               bytes_sent, streams_sent, base_settings);
      $display("checked %0d results: %0d target sizes, %0d copies, %0d literals, %0d errors",
               sb.checked, sb.kind_count[KIND_TARGET_SIZE], sb.kind_count[KIND_COPY],
               sb.kind_count[KIND_LITERAL], sb.kind_count[KIND_ERROR]);
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
